// ===== rtl/pslsr_pkg.sv =====
// Shared widths, reset values and codes for the speed loop with stall reverse.
// No dependencies; imported by pid_speed_loop_stall_reverse_unit and its testbench.
package pslsr_pkg;

    // field widths
    localparam int SPEED_W   = 16;
    localparam int MODE_W    = 2;
    localparam int GAIN_W    = 16;
    localparam int MAG_W     = 15;
    localparam int ERR_W     = 17;
    localparam int DIFF_W    = 18;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int IN_TD_W   = 24;
    localparam int OUT_TD_W  = 24;

    // product and accumulator widths
    localparam int PROD_W    = GAIN_W + ERR_W;
    localparam int PRODD_W   = GAIN_W + DIFF_W;
    localparam int ACC_W     = PRODD_W + 2;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_STOP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FEED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HOLD = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FEED_SPEED     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_SPEED  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STALL_SPEED    = 3'd7;

    // register reset values
    localparam logic signed [GAIN_W-1:0]  RST_PROP_GAIN      = 16'sd1280;
    localparam logic signed [GAIN_W-1:0]  RST_INTEG_GAIN     = 16'sd64;
    localparam logic signed [GAIN_W-1:0]  RST_DERIV_GAIN     = 16'sd0;
    localparam logic        [MAG_W-1:0]   RST_FEED_SPEED     = 15'd5500;
    localparam logic        [MAG_W-1:0]   RST_CURRENT_LIMIT  = 15'd10000;
    localparam logic        [MAG_W-1:0]   RST_INTEGRAL_LIMIT = 15'd10000;
    localparam logic signed [SPEED_W-1:0] RST_REVERSE_SPEED  = 16'sd2000;
    localparam logic        [MAG_W-1:0]   RST_STALL_SPEED    = 15'd100;

    // flags that ride along the pipeline
    typedef struct packed {
        logic protect;
        logic reversing;
    } t_flags;

endpackage

// ===== rtl/pid_speed_loop_stall_reverse_unit.sv =====
// Speed PID loop with integral clamp, stall detection and timed reverse.
// Depends on pslsr_pkg.
//
// Usage:
//   Input stream: one transaction per control tick, carrying measured speed,
//   mode (stop, feed, hold) and a protect flag. Output stream: one transaction
//   per input with the clamped drive current, a reversing flag and a windup flag.
//   Configuration: write enable, register index and data; writes take effect at
//   the clock edge; the user must make them only while the loop is idle, the block does not enforce this.
//   Throughput: one item per cycle while the output is not stalled. The first
//   stage (target select, stall counter, error and clamped error sum) closes
//   the state loop; the second stage holds the three gain products; the third
//   sums, scales, rounds toward zero and clamps into the output register.
//   Reset: all configuration registers return to their defaults, target, errors, error
//   sum, stall count and reverse count clear, the pipeline empties.
//   Stall on the output: each stage holds while the one after it is full and
//   not moving, so input is still taken until every stage is occupied.
module pid_speed_loop_stall_reverse_unit #(
    parameter int STALL_TICKS_NEEDED = 20,
    parameter int REVERSE_TICKS      = 40,
    parameter int GAIN_FRAC_BITS     = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [15:0] real_speed, [17:16] mode, [18] protect, [23:19] zero
    input  logic [pslsr_pkg::IN_TD_W-1:0]       i_s_axis_tdata,
    // output stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [15:0] drive_current, [16] reversing, [17] windup, [23:18] zero
    output logic [pslsr_pkg::OUT_TD_W-1:0]      o_m_axis_tdata,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [pslsr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pslsr_pkg::CFG_W-1:0]         i_cfg_data
);
    import pslsr_pkg::*;

    localparam int STALL_W = $clog2(STALL_TICKS_NEEDED + 1);
    localparam int REV_W   = $clog2(REVERSE_TICKS + 1);
    localparam logic [STALL_W-1:0] STALL_MAX = STALL_W'(STALL_TICKS_NEEDED);
    localparam logic [REV_W-1:0]   REV_LOAD  = REV_W'(REVERSE_TICKS);
    localparam logic signed [ACC_W-1:0] RND_BIAS =
        ACC_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

    // configuration registers
    logic signed [GAIN_W-1:0]  r_kp, r_ki, r_kd, r_rev_speed;
    logic        [MAG_W-1:0]   r_feed, r_clim, r_ilim, r_stall_speed;

    // loop state, also the stage-one payload
    logic signed [SPEED_W-1:0] r_target, n_target;
    logic signed [ERR_W-1:0]   r_err_now, n_err_now;
    logic signed [ERR_W-1:0]   r_err_sum, n_err_sum;
    logic signed [DIFF_W-1:0]  r_s1_diff, n_diff;
    logic [STALL_W-1:0]        r_stall_cnt, n_stall_cnt;
    logic [REV_W-1:0]          r_rev_left, n_rev_left;
    t_flags                    r_s1_flags, n_flags;
    logic                      r_s1_valid;

    // stage two
    logic signed [PROD_W-1:0]  r_p_prop, r_p_int;
    logic signed [PRODD_W-1:0] r_p_der;
    t_flags                    r_s2_flags;
    logic                      r_s2_windup;
    logic                      r_s2_valid;

    // output register
    logic signed [SPEED_W-1:0] r_out_drive, n_out_drive;
    logic                      r_out_rev, r_out_windup;
    logic                      r_out_valid;

    // handshake
    logic rdy1, rdy2, rdy3, s_acc;

    // stage-one combinational signals
    logic signed [SPEED_W-1:0] in_speed;
    logic [MODE_W-1:0]         in_mode;
    logic                      in_protect;
    logic [SPEED_W:0]          spd_mag;
    logic signed [DIFF_W-1:0]  sum_ext, sum_mag, ilim_ext, sum_next;
    logic                      stall_hit, rev_act;
    logic [STALL_W-1:0]        stall_inc;
    logic [REV_W-1:0]          rev_base;

    // stage-three combinational signals
    logic signed [ACC_W-1:0]   acc, acc_rnd, acc_q, clim_ext;

    // per-stage ready chain
    assign rdy3  = ~r_out_valid | i_m_axis_tready;
    assign rdy2  = ~r_s2_valid | rdy3;
    assign rdy1  = ~r_s1_valid | rdy2;
    assign s_acc = i_s_axis_tvalid & rdy1;
    assign o_s_axis_tready = rdy1;

    // input fields
    assign in_speed   = i_s_axis_tdata[SPEED_W-1:0];
    assign in_mode    = i_s_axis_tdata[SPEED_W +: MODE_W];
    assign in_protect = i_s_axis_tdata[SPEED_W+MODE_W];

    // magnitudes of speed and of the previous error sum
    assign spd_mag  = in_speed[SPEED_W-1] ? -{in_speed[SPEED_W-1], in_speed}
                                          : {in_speed[SPEED_W-1], in_speed};
    assign sum_ext  = {r_err_sum[ERR_W-1], r_err_sum};
    assign sum_mag  = r_err_sum[ERR_W-1] ? -sum_ext : sum_ext;
    assign ilim_ext = {{(DIFF_W-MAG_W){1'b0}}, r_ilim};

    // target, stall counter, reverse, error and clamped sum
    always_comb begin
        n_target = r_target;
        case (in_mode)
            MODE_STOP: n_target = '0;
            MODE_FEED: n_target = -$signed({1'b0, r_feed});
            default:   n_target = r_target;
        endcase

        stall_hit   = (spd_mag < {2'b00, r_stall_speed}) && (sum_mag == ilim_ext);
        stall_inc   = stall_hit ? r_stall_cnt + 1'b1 : '0;
        n_stall_cnt = r_stall_cnt;
        rev_base    = r_rev_left;
        if (r_rev_left == '0) begin
            if (stall_inc >= STALL_MAX) begin
                rev_base    = REV_LOAD;
                n_stall_cnt = '0;
            end else begin
                n_stall_cnt = stall_inc;
            end
        end

        rev_act    = (rev_base != '0);
        n_rev_left = rev_act ? rev_base - 1'b1 : rev_base;
        if (rev_act) begin
            n_target = r_rev_speed;
        end

        n_err_now = {n_target[SPEED_W-1], n_target} - {in_speed[SPEED_W-1], in_speed};
        n_diff    = {n_err_now[ERR_W-1], n_err_now} - {r_err_now[ERR_W-1], r_err_now};
        sum_next  = sum_ext + {n_err_now[ERR_W-1], n_err_now};
        if (sum_next > ilim_ext) begin
            n_err_sum = ilim_ext[ERR_W-1:0];
        end else if (sum_next < -ilim_ext) begin
            n_err_sum = ERR_W'(-ilim_ext);
        end else begin
            n_err_sum = sum_next[ERR_W-1:0];
        end

        n_flags.protect   = in_protect;
        n_flags.reversing = rev_act;
    end

    // sum of products, divide rounding toward zero, clamp, protect
    assign acc      = ACC_W'(r_p_prop) + ACC_W'(r_p_int) + ACC_W'(r_p_der);
    assign acc_rnd  = acc + (acc[ACC_W-1] ? RND_BIAS : '0);
    assign acc_q    = acc_rnd >>> GAIN_FRAC_BITS;
    assign clim_ext = {{(ACC_W-MAG_W){1'b0}}, r_clim};

    always_comb begin
        if (r_s2_flags.protect) begin
            n_out_drive = '0;
        end else if (acc_q > clim_ext) begin
            n_out_drive = clim_ext[SPEED_W-1:0];
        end else if (acc_q < -clim_ext) begin
            n_out_drive = SPEED_W'(-clim_ext);
        end else begin
            n_out_drive = acc_q[SPEED_W-1:0];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp          <= RST_PROP_GAIN;
            r_ki          <= RST_INTEG_GAIN;
            r_kd          <= RST_DERIV_GAIN;
            r_feed        <= RST_FEED_SPEED;
            r_clim        <= RST_CURRENT_LIMIT;
            r_ilim        <= RST_INTEGRAL_LIMIT;
            r_rev_speed   <= RST_REVERSE_SPEED;
            r_stall_speed <= RST_STALL_SPEED;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PROP_GAIN:      r_kp          <= i_cfg_data;
                REG_INTEG_GAIN:     r_ki          <= i_cfg_data;
                REG_DERIV_GAIN:     r_kd          <= i_cfg_data;
                REG_FEED_SPEED:     r_feed        <= i_cfg_data[MAG_W-1:0];
                REG_CURRENT_LIMIT:  r_clim        <= i_cfg_data[MAG_W-1:0];
                REG_INTEGRAL_LIMIT: r_ilim        <= i_cfg_data[MAG_W-1:0];
                REG_REVERSE_SPEED:  r_rev_speed   <= i_cfg_data;
                REG_STALL_SPEED:    r_stall_speed <= i_cfg_data[MAG_W-1:0];
                default: ;
            endcase
        end
    end

    // stage one: loop state, updated on each input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= '0;
            r_err_now   <= '0;
            r_err_sum   <= '0;
            r_stall_cnt <= '0;
            r_rev_left  <= '0;
            r_s1_valid  <= 1'b0;
        end else begin
            if (rdy1) begin
                r_s1_valid <= i_s_axis_tvalid;
            end
            if (s_acc) begin
                r_target    <= n_target;
                r_err_now   <= n_err_now;
                r_err_sum   <= n_err_sum;
                r_stall_cnt <= n_stall_cnt;
                r_rev_left  <= n_rev_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_diff  <= n_diff;
            r_s1_flags <= n_flags;
        end
    end

    // stage two: gain products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (rdy2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_s1_valid) begin
            r_p_prop    <= PROD_W'(r_kp) * PROD_W'(r_err_now);
            r_p_int     <= PROD_W'(r_ki) * PROD_W'(r_err_sum);
            r_p_der     <= PRODD_W'(r_kd) * PRODD_W'(r_s1_diff);
            r_s2_flags  <= r_s1_flags;
            r_s2_windup <= (sum_mag == ilim_ext);
        end
    end

    // stage three: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rdy3) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_s2_valid) begin
            r_out_drive  <= n_out_drive;
            r_out_rev    <= r_s2_flags.reversing;
            r_out_windup <= r_s2_windup;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TD_W-SPEED_W-2){1'b0}}, r_out_windup, r_out_rev,
                              r_out_drive};

    // a pending reverse keeps the stall counter cleared
    a_rev_clears_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rev_left != '0) |-> (r_stall_cnt == '0))
        else $error("stall counter running during reverse");

    // the error sum never leaves its clamp after an update
    a_sum_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (sum_mag <= ilim_ext))
        else $error("error sum outside integral limit");

    // a stalled stage-one item keeps its loop state
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !rdy2) |=> (r_s1_valid && $stable(r_err_now) && $stable(r_err_sum)))
        else $error("stage one item lost while stalled");

    // every item leaving stage one lands in stage two
    a_s2_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && rdy2) |=> r_s2_valid)
        else $error("item dropped between stage one and two");

endmodule

// ===== test/tb_pid_speed_loop_stall_reverse_unit.sv =====
// Self-checking testbench for pid_speed_loop_stall_reverse_unit: streams speed ticks through
// the loop, predicts drive current, reversing and windup flags, and compares every result.
// Depends on pslsr_pkg and the unit itself.
module tb_pid_speed_loop_stall_reverse_unit;
    import pslsr_pkg::*;

    localparam int STALL_TICKS_NEEDED = 20;
    localparam int REVERSE_TICKS      = 40;
    localparam int GAIN_FRAC_BITS     = 8;
    localparam int DRAIN_CYCLES       = 8;
    localparam int CYCLE_LIMIT        = 300000;
    localparam int NUM_PHASES         = 6;

    // mode three has no package name; the loop treats it as hold
    localparam logic [MODE_W-1:0] MODE_HOLD_ALT = 2'd3;

    typedef struct {
        logic signed [SPEED_W-1:0] drive;
        logic                      reversing;
        logic                      windup;
    } t_drive_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // [15:0] real_speed, [17:16] mode, [18] protect, [23:19] zero
    logic [IN_TD_W-1:0]     i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // [15:0] drive_current, [16] reversing, [17] windup, [23:18] zero
    logic [OUT_TD_W-1:0]    o_m_axis_tdata;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;

    // stimulus and expected results
    logic [IN_TD_W-1:0]     tick_q[$];
    t_drive_result          expected_drive_q[$];
    bit                     src_fire = 1'b0;
    int                     src_idle_pct = 0;
    int                     snk_idle_pct = 0;
    int                     mismatch_cnt = 0;
    int                     cycle_cnt = 0;

    // predicted configuration
    logic signed [GAIN_W-1:0]  kp_q = RST_PROP_GAIN;
    logic signed [GAIN_W-1:0]  ki_q = RST_INTEG_GAIN;
    logic signed [GAIN_W-1:0]  kd_q = RST_DERIV_GAIN;
    logic        [MAG_W-1:0]   feed_mag = RST_FEED_SPEED;
    logic        [MAG_W-1:0]   cur_lim = RST_CURRENT_LIMIT;
    logic        [MAG_W-1:0]   int_lim = RST_INTEGRAL_LIMIT;
    logic signed [SPEED_W-1:0] rev_speed_q = RST_REVERSE_SPEED;
    logic        [MAG_W-1:0]   stall_mag = RST_STALL_SPEED;

    // predicted loop state
    int loop_target = 0;
    int err_cur = 0;
    int err_last = 0;
    int err_acc = 0;
    int stall_run = 0;
    int reverse_ticks_left = 0;

    pid_speed_loop_stall_reverse_unit #(
        .STALL_TICKS_NEEDED (STALL_TICKS_NEEDED),
        .REVERSE_TICKS      (REVERSE_TICKS),
        .GAIN_FRAC_BITS     (GAIN_FRAC_BITS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // one control tick of the speed loop: target, stall/reverse, pid, clamp
    function automatic t_drive_result step_speed_loop(input logic signed [SPEED_W-1:0] speed,
                                                      input logic [MODE_W-1:0] mode,
                                                      input logic protect);
        t_drive_result res;
        int            spd;
        int            ilim;
        int            clim;
        int            spd_mag;
        int            acc_mag;
        longint        acc;
        spd = int'(speed);
        ilim = int'(int_lim);
        clim = int'(cur_lim);
        res.reversing = 1'b0;

        if (mode == MODE_FEED) begin
            loop_target = -int'(feed_mag);
        end else if (mode == MODE_STOP) begin
            loop_target = 0;
        end

        // stall counting only while no reverse is pending
        if (reverse_ticks_left == 0) begin
            spd_mag = (spd < 0) ? -spd : spd;
            acc_mag = (err_acc < 0) ? -err_acc : err_acc;
            if (spd_mag < int'(stall_mag) && acc_mag == ilim) begin
                stall_run++;
            end else begin
                stall_run = 0;
            end
            if (stall_run >= STALL_TICKS_NEEDED) begin
                reverse_ticks_left = REVERSE_TICKS;
                stall_run = 0;
            end
        end

        if (reverse_ticks_left > 0) begin
            loop_target = int'(rev_speed_q);
            reverse_ticks_left--;
            res.reversing = 1'b1;
        end

        // error terms with clamped integral
        err_last = err_cur;
        err_cur = loop_target - spd;
        err_acc = err_acc + err_cur;
        if (err_acc > ilim) err_acc = ilim;
        if (err_acc < -ilim) err_acc = -ilim;

        acc = longint'(kp_q) * err_cur + longint'(ki_q) * err_acc
            + longint'(kd_q) * (err_cur - err_last);
        acc = acc / (longint'(1) << GAIN_FRAC_BITS);
        if (acc > clim) acc = clim;
        if (acc < -clim) acc = -clim;

        res.drive = protect ? '0 : acc[SPEED_W-1:0];
        acc_mag = (err_acc < 0) ? -err_acc : err_acc;
        res.windup = (acc_mag == ilim);
        return res;
    endfunction

    function automatic void note_mismatch(input string what, input int want, input int got);
        mismatch_cnt++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function automatic void push_tick(input logic signed [SPEED_W-1:0] speed,
                                      input logic [MODE_W-1:0] mode, input logic protect);
        tick_q.push_back({5'b0, protect, mode, speed});
    endfunction

    // full-range speed with extra weight on the edges
    function automatic logic signed [SPEED_W-1:0] pick_speed();
        logic signed [SPEED_W-1:0] s;
        case ($urandom_range(9, 0))
            0: s = 16'sh8000;
            1: s = 16'sh7FFF;
            2: s = SPEED_W'(int'($urandom_range(2, 0)) - 1);
            default: s = SPEED_W'($urandom);
        endcase
        return s;
    endfunction

    // speed inside the stall window
    function automatic logic signed [SPEED_W-1:0] pick_slow_speed();
        int s;
        s = 0;
        if (stall_mag > 1) s = $urandom_range(int'(stall_mag) - 1, 0);
        if ($urandom_range(1, 0) == 1) s = -s;
        return s[SPEED_W-1:0];
    endfunction

    // feed against a blocked motor long enough to wind up and trigger a reverse
    function automatic int add_stall_run();
        int                  len;
        int                  roll;
        logic [MODE_W-1:0]   mode;
        logic signed [SPEED_W-1:0] speed;
        len = $urandom_range(70, 20);
        for (int k = 0; k < len; k++) begin
            roll = $urandom_range(99, 0);
            if (k == 0 || roll < 15) begin
                mode = MODE_FEED;
            end else if (roll < 22) begin
                mode = MODE_STOP;
            end else begin
                mode = ($urandom_range(3, 0) == 0) ? MODE_HOLD_ALT : MODE_HOLD;
            end
            speed = ($urandom_range(99, 0) < 4) ? pick_speed() : pick_slow_speed();
            push_tick(speed, mode, $urandom_range(9, 0) == 0);
        end
        return len;
    endfunction

    // unstructured ticks
    function automatic int add_noise_run();
        int len;
        len = $urandom_range(12, 1);
        for (int k = 0; k < len; k++) begin
            push_tick(pick_speed(), MODE_W'($urandom_range(3, 0)), 1'($urandom_range(1, 0)));
        end
        return len;
    endfunction

    function automatic void add_random_ticks(input int n_items);
        int added;
        added = 0;
        while (added < n_items) begin
            if ($urandom_range(99, 0) < 65) begin
                added += add_stall_run();
            end else begin
                added += add_noise_run();
            end
        end
    endfunction

    // field extremes, every mode, protect on both sides
    function automatic void add_directed_ticks();
        push_tick(16'sd0, MODE_STOP, 1'b0);
        push_tick(16'sh7FFF, MODE_FEED, 1'b0);
        push_tick(16'sh8000, MODE_FEED, 1'b0);
        push_tick(16'sd0, MODE_HOLD, 1'b0);
        push_tick(16'sd0, MODE_HOLD_ALT, 1'b0);
        push_tick(16'sh8000, MODE_STOP, 1'b1);
        push_tick(16'sh7FFF, MODE_HOLD, 1'b1);
        push_tick(16'sd1, MODE_FEED, 1'b0);
        push_tick(-16'sd1, MODE_HOLD_ALT, 1'b1);
        push_tick(16'sd99, MODE_FEED, 1'b0);
        push_tick(-16'sd99, MODE_FEED, 1'b0);
        push_tick(16'sd100, MODE_HOLD, 1'b0);
        push_tick(-16'sd100, MODE_STOP, 1'b0);
    endfunction

    // register write on the config port, mirrored into the prediction
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        case (idx)
            REG_PROP_GAIN:      kp_q = value;
            REG_INTEG_GAIN:     ki_q = value;
            REG_DERIV_GAIN:     kd_q = value;
            REG_FEED_SPEED:     feed_mag = value[MAG_W-1:0];
            REG_CURRENT_LIMIT:  cur_lim = value[MAG_W-1:0];
            REG_INTEGRAL_LIMIT: int_lim = value[MAG_W-1:0];
            REG_REVERSE_SPEED:  rev_speed_q = value;
            REG_STALL_SPEED:    stall_mag = value[MAG_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all_regs(input int kp, input int ki, input int kd, input int feed,
                                  input int clim, input int ilim, input int rev, input int stall);
        write_reg(REG_PROP_GAIN, kp[CFG_W-1:0]);
        write_reg(REG_INTEG_GAIN, ki[CFG_W-1:0]);
        write_reg(REG_DERIV_GAIN, kd[CFG_W-1:0]);
        write_reg(REG_FEED_SPEED, feed[CFG_W-1:0]);
        write_reg(REG_CURRENT_LIMIT, clim[CFG_W-1:0]);
        write_reg(REG_INTEGRAL_LIMIT, ilim[CFG_W-1:0]);
        write_reg(REG_REVERSE_SPEED, rev[CFG_W-1:0]);
        write_reg(REG_STALL_SPEED, stall[CFG_W-1:0]);
    endtask

    // hold off until every queued tick has been answered and the pipe is empty
    task automatic wait_drained();
        while (tick_q.size() != 0 || i_s_axis_tvalid || expected_drive_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // input driver, changes on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || src_fire) begin
            if (tick_q.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= tick_q.pop_front();
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
        i_m_axis_tready <= ($urandom_range(99, 0) >= snk_idle_pct);
    end

    // monitor: check results, predict accepted ticks
    always @(posedge i_clk) begin : monitor
        t_drive_result             want;
        logic signed [SPEED_W-1:0] got_drive;
        logic                      got_rev;
        logic                      got_wind;
        if (!i_rst_n) begin
            src_fire = 1'b0;
        end else begin
            // result transaction
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got_drive = o_m_axis_tdata[15:0];
                got_rev = o_m_axis_tdata[16];
                got_wind = o_m_axis_tdata[17];
                if (expected_drive_q.size() == 0) begin
                    note_mismatch("unexpected result, drive_current", 0, int'(got_drive));
                end else begin
                    want = expected_drive_q.pop_front();
                    if (got_drive !== want.drive)
                        note_mismatch("drive_current", int'(want.drive), int'(got_drive));
                    if (got_rev !== want.reversing)
                        note_mismatch("reversing", int'(want.reversing), int'(got_rev));
                    if (got_wind !== want.windup)
                        note_mismatch("windup", int'(want.windup), int'(got_wind));
                end
            end
            // input transaction
            src_fire = i_s_axis_tvalid && o_s_axis_tready;
            if (src_fire) begin
                expected_drive_q.push_back(step_speed_loop(i_s_axis_tdata[15:0],
                                                           i_s_axis_tdata[17:16],
                                                           i_s_axis_tdata[18]));
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // reset, then one phase per register setting
    initial begin
        src_idle_pct = 32;
        snk_idle_pct = 60;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            src_idle_pct = (phase < 2) ? 32 : ((phase < 4) ? 60 : 0);
            snk_idle_pct = (phase < 2) ? 60 : ((phase < 4) ? 32 : 0);
            case (phase)
                // upper extremes, stall window almost everywhere
                1: write_all_regs(32767, -32768, 32767, 32767, 32767, 32767, -32768, 32767);
                // lower extremes: zero integral limit, zero stall speed, zero clamp
                2: write_all_regs(-32768, 32767, -32768, 0, 0, 0, 32767, 0);
                3: write_all_regs($urandom_range(65535, 0), $urandom_range(65535, 0),
                                  $urandom_range(65535, 0), $urandom_range(20000, 1000),
                                  $urandom_range(32767, 1), $urandom_range(15000, 100),
                                  $urandom_range(65535, 0), $urandom_range(3000, 10));
                // tight integral limit so stalls come quickly
                4: write_all_regs($urandom_range(4000, 0) - 2000, $urandom_range(4000, 0) - 2000,
                                  $urandom_range(4000, 0) - 2000, $urandom_range(3000, 1),
                                  $urandom_range(5000, 500), $urandom_range(200, 1),
                                  $urandom_range(65535, 0), $urandom_range(500, 1));
                5: write_all_regs(int'(RST_PROP_GAIN), int'(RST_INTEG_GAIN), 256,
                                  int'(RST_FEED_SPEED), int'(RST_CURRENT_LIMIT),
                                  int'(RST_INTEGRAL_LIMIT), int'(RST_REVERSE_SPEED),
                                  int'(RST_STALL_SPEED));
                default: ;
            endcase
            if (phase == 0) add_directed_ticks();
            add_random_ticks((phase == 0) ? 212 : 235);
            wait_drained();
        end
        if (mismatch_cnt == 0 && expected_drive_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pslsr_pkg.sv
rtl/pid_speed_loop_stall_reverse_unit.sv
test/tb_pid_speed_loop_stall_reverse_unit.sv
